@@ hw/rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  localparam int COL_W    = 7;
  localparam int ROW_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int NUM_W    = 32;
  localparam int INDEX_W  = 15;
  localparam int ATTR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int DIGIT_W  = 4;
  localparam int NDIGITS  = 10;
  localparam int BCD_W    = NDIGITS * DIGIT_W;
  localparam int NDIG_W   = 4;
  localparam int BITCNT_W = 5;

  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 2;

  localparam logic [ROW_W-1:0]  ROW_MAX   = 8'd255;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd2;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_HEX  = 2'd1,
    OP_DEC  = 2'd2,
    OP_MOVE = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHAR  = 8'b0000_0010,
    ST_CONV  = 8'b0000_0100,
    ST_SKIP  = 8'b0000_1000,
    ST_SIGN  = 8'b0001_0000,
    ST_ZERO  = 8'b0010_0000,
    ST_XCHR  = 8'b0100_0000,
    ST_DIGIT = 8'b1000_0000
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/text_console_writer.sv @@
`timescale 1ns / 1ps

// Channel    Dir  Fields (low bit up)
// s_axis     in   tuser: op; tdata: char_code, number, new_column, new_row
// m_axis     out  tdata: cell_index, cell_char, attribute; tuser: write_char, off_screen;
//                 tlast: last
// cfg        in   cfg_we, cfg_index (0 foreground, 1 background), cfg_data
//
// One item at a time; s_axis_tready is high only while idle.
// Put char: accept, then the write. Hex: accept, a scan past leading zero digits,
// a minus sign if negative, the 0x prefix, then the digits. Decimal: accept, a
// double-dabble pass over all 32 input bits, the same scan and sign, then the digits. Newline and move: no write.
// Each write waits while m_axis stalls; a result held in the
// output register does not block the next accept. Reset zeroes the cursor
// and loads the default colors.

module text_console_writer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // char_code[7:0], number[39:8], new_column[46:40], new_row[54:47], zero pad
  input  logic [tcw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // op[1:0]
  input  logic [tcw_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cell_index[14:0], cell_char[22:15], attribute[30:23], zero pad
  output logic [tcw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // write_char[0], off_screen[1]
  output logic [tcw_pkg::M_TUSER_W-1:0]   m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data
);

  tcw_pkg::state_t                    state;
  logic [tcw_pkg::COLOR_W-1:0]        fg;
  logic [tcw_pkg::COLOR_W-1:0]        bg;
  logic [tcw_pkg::COL_W-1:0]          col;
  logic [tcw_pkg::ROW_W-1:0]          row;

  logic                               item_hex;
  logic                               item_neg;
  logic [tcw_pkg::CHAR_W-1:0]         item_char;
  logic [tcw_pkg::NUM_W-1:0]          bin;
  logic [tcw_pkg::BCD_W-1:0]          digits;
  logic [tcw_pkg::BCD_W-1:0]          digits_adj;
  logic [tcw_pkg::NDIG_W-1:0]         ndig;
  logic [tcw_pkg::BITCNT_W-1:0]       bit_cnt;

  tcw_pkg::op_t                       in_op;
  logic [tcw_pkg::CHAR_W-1:0]         in_char;
  logic [tcw_pkg::NUM_W-1:0]          in_num;
  logic [tcw_pkg::COL_W-1:0]          in_col;
  logic [tcw_pkg::ROW_W-1:0]          in_row;
  logic [tcw_pkg::NUM_W-1:0]          in_mag;
  logic                               in_fire;

  logic                               emit;
  logic                               emit_wr;
  logic                               emit_last;
  logic [tcw_pkg::CHAR_W-1:0]         emit_char;
  logic                               out_free;
  logic                               fire;
  logic [tcw_pkg::DIGIT_W-1:0]        top_digit;

  logic [tcw_pkg::COL_W:0]            col_inc;
  logic [tcw_pkg::ROW_W-1:0]          row_inc;
  logic [tcw_pkg::INDEX_W-1:0]        cell_index;

  logic [tcw_pkg::INDEX_W-1:0]        out_index;
  logic [tcw_pkg::CHAR_W-1:0]         out_char;
  logic [tcw_pkg::ATTR_W-1:0]         out_attr;
  logic                               out_wr;
  logic                               out_off;
  logic                               out_last;
  logic                               out_valid;

  assign in_op   = tcw_pkg::op_t'(s_axis_tuser);
  assign in_char = s_axis_tdata[7:0];
  assign in_num  = s_axis_tdata[39:8];
  assign in_col  = s_axis_tdata[46:40];
  assign in_row  = s_axis_tdata[54:47];
  assign in_mag  = in_num[tcw_pkg::NUM_W-1] ? (~in_num + 1'b1) : in_num;

  assign s_axis_tready = (state == tcw_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign top_digit = digits[tcw_pkg::BCD_W-1 -: tcw_pkg::DIGIT_W];
  assign out_free  = !out_valid || m_axis_tready;
  assign fire      = emit && out_free;

  assign col_inc    = {1'b0, col} + 1'b1;
  assign row_inc    = (row == tcw_pkg::ROW_MAX) ? row : row + 1'b1;
  assign cell_index = tcw_pkg::INDEX_W'(row) * tcw_pkg::INDEX_W'(tcw_pkg::COLS)
                    + tcw_pkg::INDEX_W'(col);

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < tcw_pkg::NDIGITS; i++) begin
      digits_adj[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] =
        (digits[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] >= 4'd5)
          ? digits[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W] + 4'd3
          : digits[i*tcw_pkg::DIGIT_W +: tcw_pkg::DIGIT_W];
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_wr   = 1'b1;
    emit_last = 1'b0;
    emit_char = tcw_pkg::CHAR_ZERO;
    unique case (state)
      tcw_pkg::ST_CHAR: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_wr   = (item_char != tcw_pkg::CHAR_CR);
        emit_char = (item_char == tcw_pkg::CHAR_CR) ? '0 : item_char;
      end
      tcw_pkg::ST_SIGN: begin
        emit      = 1'b1;
        emit_char = tcw_pkg::CHAR_MINUS;
      end
      tcw_pkg::ST_ZERO: begin
        emit      = 1'b1;
        emit_char = tcw_pkg::CHAR_ZERO;
      end
      tcw_pkg::ST_XCHR: begin
        emit      = 1'b1;
        emit_char = tcw_pkg::CHAR_X;
      end
      tcw_pkg::ST_DIGIT: begin
        emit      = 1'b1;
        emit_last = (ndig == tcw_pkg::NDIG_W'(1));
        emit_char = tcw_pkg::digit_char(top_digit);
      end
      tcw_pkg::ST_IDLE, tcw_pkg::ST_CONV, tcw_pkg::ST_SKIP: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcw_pkg::FG_RESET;
      bg <= tcw_pkg::BG_RESET;
    end else if (cfg_we) begin
      unique case (tcw_pkg::reg_idx_t'(cfg_index))
        tcw_pkg::REG_FG: fg <= cfg_data;
        tcw_pkg::REG_BG: bg <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_index <= cell_index;
      out_char  <= emit_char;
      out_attr  <= {bg, fg};
      out_wr    <= emit_wr;
      out_off   <= (row >= tcw_pkg::ROW_W'(tcw_pkg::ROWS));
      out_last  <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_attr, out_char, out_index};
  assign m_axis_tuser  = {out_off, out_wr};
  assign m_axis_tlast  = out_last;

  // cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire && in_op == tcw_pkg::OP_MOVE) begin
      col <= (in_col >= tcw_pkg::COL_W'(tcw_pkg::COLS))
               ? tcw_pkg::COL_W'(tcw_pkg::COLS - 1) : in_col;
      row <= in_row;
    end else if (in_fire && in_op == tcw_pkg::OP_CHAR && in_char == tcw_pkg::CHAR_LF) begin
      col <= '0;
      row <= row_inc;
    end else if (fire) begin
      if (col_inc >= (tcw_pkg::COL_W + 1)'(tcw_pkg::COLS)) begin
        col <= '0;
        row <= row_inc;
      end else begin
        col <= col_inc[tcw_pkg::COL_W-1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_IDLE;
    end else begin
      unique case (state)
        tcw_pkg::ST_IDLE: begin
          if (in_fire) begin
            item_char <= in_char;
            item_neg  <= in_num[tcw_pkg::NUM_W-1];
            item_hex  <= (in_op == tcw_pkg::OP_HEX);
            ndig      <= tcw_pkg::NDIG_W'(tcw_pkg::NDIGITS);
            bit_cnt   <= tcw_pkg::BITCNT_W'(tcw_pkg::NUM_W - 1);
            bin       <= in_mag;
            unique case (in_op)
              tcw_pkg::OP_CHAR: begin
                if (in_char != tcw_pkg::CHAR_LF) begin
                  state <= tcw_pkg::ST_CHAR;
                end
              end
              tcw_pkg::OP_HEX: begin
                digits <= tcw_pkg::BCD_W'(in_mag);
                state  <= tcw_pkg::ST_SKIP;
              end
              tcw_pkg::OP_DEC: begin
                digits <= '0;
                state  <= tcw_pkg::ST_CONV;
              end
              tcw_pkg::OP_MOVE: begin
                state <= tcw_pkg::ST_IDLE;
              end
              default: ;
            endcase
          end
        end
        tcw_pkg::ST_CHAR: begin
          if (fire) begin
            state <= tcw_pkg::ST_IDLE;
          end
        end
        tcw_pkg::ST_CONV: begin
          digits  <= {digits_adj[tcw_pkg::BCD_W-2:0], bin[tcw_pkg::NUM_W-1]};
          bin     <= {bin[tcw_pkg::NUM_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= tcw_pkg::ST_SKIP;
          end
        end
        tcw_pkg::ST_SKIP: begin
          if (top_digit == '0 && ndig != tcw_pkg::NDIG_W'(1)) begin
            digits <= {digits[tcw_pkg::BCD_W-tcw_pkg::DIGIT_W-1:0],
                       tcw_pkg::DIGIT_W'(0)};
            ndig   <= ndig - 1'b1;
          end else if (item_neg) begin
            state <= tcw_pkg::ST_SIGN;
          end else if (item_hex) begin
            state <= tcw_pkg::ST_ZERO;
          end else begin
            state <= tcw_pkg::ST_DIGIT;
          end
        end
        tcw_pkg::ST_SIGN: begin
          if (fire) begin
            state <= item_hex ? tcw_pkg::ST_ZERO : tcw_pkg::ST_DIGIT;
          end
        end
        tcw_pkg::ST_ZERO: begin
          if (fire) begin
            state <= tcw_pkg::ST_XCHR;
          end
        end
        tcw_pkg::ST_XCHR: begin
          if (fire) begin
            state <= tcw_pkg::ST_DIGIT;
          end
        end
        tcw_pkg::ST_DIGIT: begin
          if (fire) begin
            digits <= {digits[tcw_pkg::BCD_W-tcw_pkg::DIGIT_W-1:0],
                       tcw_pkg::DIGIT_W'(0)};
            ndig   <= ndig - 1'b1;
            if (ndig == tcw_pkg::NDIG_W'(1)) begin
              state <= tcw_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= tcw_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 16;
  localparam int NPHASES      = 5;
  localparam int NSCRIPT      = 23;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [CHAR_W-1:0]  glyph;
    logic               char_en;
    logic [ATTR_W-1:0]  attr;
    logic               off;
    logic               fin;
  } cell_write_t;

  typedef struct packed {
    op_t                op;
    logic [CHAR_W-1:0]  code;
    logic [NUM_W-1:0]   value;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               has_cell;
    cell_write_t        want_cell;
  } stim_row_t;

  localparam cell_write_t NO_CELL = '0;

  localparam stim_row_t SCRIPT [NSCRIPT] = '{
    '{OP_CHAR, 8'h41, 32'h0,         7'd0,   8'd0,   1'b1,
      '{15'd0,     8'h41, 1'b1, 8'h02, 1'b0, 1'b1}},
    '{OP_CHAR, 8'h0D, 32'h0,         7'd0,   8'd0,   1'b1,
      '{15'd1,     8'h00, 1'b0, 8'h02, 1'b0, 1'b1}},
    '{OP_CHAR, 8'h0A, 32'h0,         7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_CHAR, 8'h00, 32'h0,         7'd0,   8'd0,   1'b1,
      '{15'd80,    8'h00, 1'b1, 8'h02, 1'b0, 1'b1}},
    '{OP_CHAR, 8'hFF, 32'h0,         7'd0,   8'd0,   1'b1,
      '{15'd81,    8'hFF, 1'b1, 8'h02, 1'b0, 1'b1}},
    '{OP_HEX,  8'h00, 32'h0,         7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_DEC,  8'h00, 32'h0,         7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_HEX,  8'h00, 32'h7FFF_FFFF, 7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_HEX,  8'h00, 32'h8000_0000, 7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_DEC,  8'h00, 32'h8000_0000, 7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_DEC,  8'h00, 32'h7FFF_FFFF, 7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_HEX,  8'h00, 32'hFFFF_FFFF, 7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_DEC,  8'h00, 32'hFFFF_FFFF, 7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_MOVE, 8'h00, 32'h0,         7'd127, 8'd255, 1'b0, NO_CELL},
    '{OP_CHAR, 8'h5A, 32'h0,         7'd0,   8'd0,   1'b1,
      '{15'd20479, 8'h5A, 1'b1, 8'h02, 1'b1, 1'b1}},
    '{OP_CHAR, 8'h7A, 32'h0,         7'd0,   8'd0,   1'b1,
      '{15'd20400, 8'h7A, 1'b1, 8'h02, 1'b1, 1'b1}},
    '{OP_CHAR, 8'h0A, 32'h0,         7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_MOVE, 8'h00, 32'h0,         7'd79,  8'd24,  1'b0, NO_CELL},
    '{OP_DEC,  8'h00, 32'd123,       7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_MOVE, 8'h00, 32'h0,         7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_HEX,  8'h00, 32'h1234_ABCD, 7'd0,   8'd0,   1'b0, NO_CELL},
    '{OP_MOVE, 8'h00, 32'h0,         7'd80,  8'd25,  1'b0, NO_CELL},
    '{OP_CHAR, 8'h78, 32'h0,         7'd0,   8'd0,   1'b1,
      '{15'd2079,  8'h78, 1'b1, 8'h02, 1'b1, 1'b1}}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [COLOR_W-1:0]   cfg_data = '0;

  logic [COL_W-1:0]   cur_col = '0;
  logic [ROW_W-1:0]   cur_row = '0;
  logic [COLOR_W-1:0] fg_color = FG_RESET;
  logic [COLOR_W-1:0] bg_color = BG_RESET;
  cell_write_t        pending_cells[$];
  cell_write_t        seen;
  cell_write_t        owed;
  int                 mismatches = 0;
  string              glyphs = "0123456789ABCDEF";

  bit   src_calm  = 1'b0;
  logic sink_calm = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  text_console_writer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void bump_row();
    if (cur_row != ROW_MAX) cur_row++;
  endfunction

  function automatic void put_cell(logic [CHAR_W-1:0] glyph, logic char_en, logic fin);
    cell_write_t c;
    c.idx     = INDEX_W'(cur_row * COLS + cur_col);
    c.glyph   = glyph;
    c.char_en = char_en;
    c.attr    = {bg_color, fg_color};
    c.off     = (cur_row >= ROWS);
    c.fin     = fin;
    pending_cells.push_back(c);
    if (cur_col >= COL_W'(COLS - 1)) begin
      cur_col = '0;
      bump_row();
    end else begin
      cur_col++;
    end
  endfunction

  function automatic void put_number(logic [NUM_W-1:0] value, int radix);
    logic [CHAR_W-1:0] text [NDIGITS + 1];
    logic [CHAR_W-1:0] rev [NDIGITS];
    logic [NUM_W-1:0]  mag;
    int                nd;
    int                len;
    nd  = 0;
    len = 0;
    mag = value[NUM_W-1] ? -value : value;
    do begin
      rev[nd] = glyphs[mag % radix];
      mag = mag / radix;
      nd++;
    end while (mag != 0 && nd < NDIGITS);
    if (value[NUM_W-1]) begin
      text[len] = CHAR_MINUS;
      len++;
    end
    if (radix == 16) begin
      text[len]     = CHAR_ZERO;
      text[len + 1] = CHAR_X;
      len += 2;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      text[len] = rev[i];
      len++;
    end
    for (int i = 0; i < len; i++) put_cell(text[i], 1'b1, i == len - 1);
  endfunction

  function automatic void predict_cells(stim_row_t item);
    case (item.op)
      OP_CHAR: begin
        if (item.code == CHAR_LF) begin
          cur_col = '0;
          bump_row();
        end else if (item.code == CHAR_CR) begin
          put_cell('0, 1'b0, 1'b1);
        end else begin
          put_cell(item.code, 1'b1, 1'b1);
        end
      end
      OP_HEX: put_number(item.value, 16);
      OP_DEC: put_number(item.value, 10);
      default: begin
        cur_col = (item.col >= COLS) ? COL_W'(COLS - 1) : item.col;
        cur_row = item.row;
      end
    endcase
  endfunction

  function automatic stim_row_t random_item();
    stim_row_t item;
    int        pick;
    item = '0;
    pick = $urandom_range(0, 99);
    if (pick < 35) item.op = OP_CHAR;
    else if (pick < 55) item.op = OP_HEX;
    else if (pick < 80) item.op = OP_DEC;
    else item.op = OP_MOVE;
    case ($urandom_range(0, 9))
      0: item.code = CHAR_LF;
      1: item.code = CHAR_CR;
      default: item.code = CHAR_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0: item.value = 32'h8000_0000;
      1: item.value = 32'h7FFF_FFFF;
      2: item.value = '0;
      3, 4, 5: begin
        item.value = $urandom_range(0, 999);
        if ($urandom_range(0, 1) == 1) item.value = -item.value;
      end
      default: item.value = $urandom;
    endcase
    item.col = COL_W'($urandom_range(0, 127));
    if ($urandom_range(0, 4) == 0) item.row = ROW_W'($urandom_range(0, 255));
    else item.row = ROW_W'($urandom_range(0, ROWS - 1));
    return item;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 40) $display("%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(stim_row_t item);
    while (!src_calm && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, item.row, item.col, item.value, item.code};
    s_axis_tuser  <= item.op;
    do @(posedge clk); while (!s_axis_tready);
    predict_cells(item);
    if (item.has_cell) begin
      void'(pending_cells.pop_back());
      pending_cells.push_back(item.want_cell);
    end
  endtask

  task automatic wait_for_cells(int extra);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_cells.size() != 0);
    @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FG;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= REG_BG;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we   <= 1'b0;
    fg_color = fg;
    bg_color = bg;
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && (sink_calm || $urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      seen = {m_axis_tdata[14:0], m_axis_tdata[22:15], m_axis_tuser[0],
              m_axis_tdata[30:23], m_axis_tuser[1], m_axis_tlast};
      if (pending_cells.size() == 0) begin
        flag_mismatch("write with nothing pending, cell_index", seen.idx, '0);
      end else begin
        owed = pending_cells.pop_front();
        if (seen.idx !== owed.idx) flag_mismatch("cell_index", seen.idx, owed.idx);
        if (seen.glyph !== owed.glyph) flag_mismatch("cell_char", seen.glyph, owed.glyph);
        if (seen.char_en !== owed.char_en)
          flag_mismatch("write_char", seen.char_en, owed.char_en);
        if (seen.attr !== owed.attr) flag_mismatch("attribute", seen.attr, owed.attr);
        if (seen.off !== owed.off) flag_mismatch("off_screen", seen.off, owed.off);
        if (seen.fin !== owed.fin) flag_mismatch("last", seen.fin, owed.fin);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    stim_row_t item;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NSCRIPT; i++) send_item(SCRIPT[i]);
    wait_for_cells(DRAIN_CYCLES);
    for (int p = 0; p < NPHASES; p++) begin
      case (p)
        0: set_colors(4'd0, 4'd0);
        1: set_colors(4'd15, 4'd15);
        2: set_colors(4'd0, 4'd15);
        default: set_colors(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)));
      endcase
      src_calm = (p == 0);
      sink_calm <= (p == 0);
      // hold the sink off while items keep coming
      if (p == 1) hold_req <= ~hold_req;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) wait_for_cells(0);
        item = random_item();
        send_item(item);
      end
      wait_for_cells(DRAIN_CYCLES);
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
